// ===== rtl/kpi_pkg.sv =====
// ----------------------------------------------------------------------------
// kpi_pkg
// Shared types, constants and helpers of the keyframe pose interpolator.
// ----------------------------------------------------------------------------
package kpi_pkg;

	localparam int ANGLE_W = 16;
	localparam int JOINTS  = 6;
	localparam int POSE_W  = ANGLE_W * JOINTS;
	localparam int STEP_W  = 8;
	localparam int JOINT_W = 3;

	// Divider retires this many quotient bits per cycle
	localparam int DIV_BITS   = 4;
	localparam int DIV_CYCLES = ANGLE_W / DIV_BITS;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

	localparam logic [STEP_W-1:0] STEP_COUNT_RESET = 8'd10;

	typedef logic [POSE_W-1:0] pose_t;

	typedef enum logic [1:0] {
		CMD_STORE  = 2'd0,
		CMD_PLAY   = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_IGNORE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_DIV_GO,
		ST_DIV_WAIT
	} state_t;

	// Clamp a 17 bit signed value to 16 bit signed
	function automatic logic signed [ANGLE_W-1:0] sat17(input logic signed [ANGLE_W:0] v);
		logic signed [ANGLE_W-1:0] r;
		if (v[ANGLE_W] != v[ANGLE_W-1])
			r = v[ANGLE_W] ? {1'b1, {(ANGLE_W-1){1'b0}}} : {1'b0, {(ANGLE_W-1){1'b1}}};
		else
			r = v[ANGLE_W-1:0];
		return r;
	endfunction

endpackage

// ===== rtl/kpi_pose_ram.sv =====
// ----------------------------------------------------------------------------
// kpi_pose_ram
// Keyframe table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kpi_pose_ram #(
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  kpi_pkg::pose_t     wr_data,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output kpi_pkg::pose_t     rd_data
);
	import kpi_pkg::*;

	pose_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/kpi_div.sv =====
// ----------------------------------------------------------------------------
// kpi_div
// Signed 17 by unsigned 8 bit divider, truncating toward zero, with the
// quotient clamped to 16 bit signed. Restoring, several bits per cycle.
// ----------------------------------------------------------------------------
module kpi_div (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [kpi_pkg::ANGLE_W:0]       dividend,
	input  logic [kpi_pkg::STEP_W-1:0]             divisor,
	output logic                                   done,
	output logic signed [kpi_pkg::ANGLE_W-1:0]     quotient
);
	import kpi_pkg::*;

	logic                  run_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  neg_q;
	logic [ANGLE_W-1:0]    num_q;
	logic [STEP_W-1:0]     rem_q;
	logic [STEP_W-1:0]     div_q;
	logic signed [ANGLE_W-1:0] quot_q;

	logic [ANGLE_W:0]      mag;
	logic [ANGLE_W-1:0]    num_d;
	logic [STEP_W-1:0]     rem_d;
	logic signed [ANGLE_W:0] signed_q;

	assign mag = dividend[ANGLE_W] ? (ANGLE_W+1)'(-dividend) : dividend;

	// Shift the dividend out at the top and the quotient in at the bottom
	always_comb begin
		logic [STEP_W:0] r;
		num_d = num_q;
		rem_d = rem_q;
		for (int k = 0; k < DIV_BITS; k++) begin
			r = {rem_d, num_d[ANGLE_W-1]};
			num_d = {num_d[ANGLE_W-2:0], 1'b0};
			if (r >= {1'b0, div_q}) begin
				r = r - {1'b0, div_q};
				num_d[0] = 1'b1;
			end
			rem_d = r[STEP_W-1:0];
		end
	end

	assign signed_q = neg_q ? -$signed({1'b0, num_d}) : $signed({1'b0, num_d});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[ANGLE_W];
			num_q <= mag[ANGLE_W-1:0];
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			num_q <= num_d;
			rem_q <= rem_d;
			if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
				quot_q <= sat17(signed_q);
			end
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

// ===== rtl/keyframe_pose_interpolator.sv =====
// ----------------------------------------------------------------------------
// keyframe_pose_interpolator
// Keyframe player for six Q8.8 joint angles with linear interpolation.
//
//   channel  ports                                   handshake
//   command  start, busy, command, *_angle           start & !busy
//   result   done, *_now, playing, frames_stored     done, one cycle
//   config   cfg_wr_en, cfg_wr_data                  cfg_wr_en
//
// Store, stop, plain tick and unused codes leave the block idle; the result
// strobes on the next cycle, when a new command may already be accepted.
// Play start and segment change hold busy through two table reads, then
// six sequential divisions, each a launch, the divider's run and a handoff;
// the result strobes in the first cycle with busy low.
// Reset clears pose, increments, counters and flags; the table needs none.
// The receiver cannot stall; busy only holds off new commands.
// ----------------------------------------------------------------------------
module keyframe_pose_interpolator #(
	parameter int TABLE_DEPTH = 512
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [kpi_pkg::STEP_W-1:0]            cfg_wr_data,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [1:0]                            command,
	input  logic signed [kpi_pkg::ANGLE_W-1:0]    ring_angle,
	input  logic signed [kpi_pkg::ANGLE_W-1:0]    middle_angle,
	input  logic signed [kpi_pkg::ANGLE_W-1:0]    little_angle,
	input  logic signed [kpi_pkg::ANGLE_W-1:0]    wrist_angle,
	input  logic signed [kpi_pkg::ANGLE_W-1:0]    thumb_angle,
	input  logic signed [kpi_pkg::ANGLE_W-1:0]    pointer_angle,
	output logic                                  done,
	output logic signed [kpi_pkg::ANGLE_W-1:0]    ring_now,
	output logic signed [kpi_pkg::ANGLE_W-1:0]    middle_now,
	output logic signed [kpi_pkg::ANGLE_W-1:0]    little_now,
	output logic signed [kpi_pkg::ANGLE_W-1:0]    wrist_now,
	output logic signed [kpi_pkg::ANGLE_W-1:0]    thumb_now,
	output logic signed [kpi_pkg::ANGLE_W-1:0]    pointer_now,
	output logic                                  playing,
	output logic [9:0]                            frames_stored
);
	import kpi_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int SW = CW + 1;

	state_t state_q, state_d;

	logic [STEP_W-1:0]  step_count_q;
	logic [CW-1:0]      count_q;
	logic               playing_q;
	logic [AW-1:0]      seg_q;
	logic [STEP_W-1:0]  tick_q;
	logic               first_q;
	logic [JOINT_W-1:0] joint_q;
	logic               done_q;
	pose_t              cur_q;
	pose_t              inc_q;
	pose_t              row_a_q;

	pose_t              pose_in;
	pose_t              pose_sum;
	pose_t              rd_data;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic               accept;
	logic               room;
	logic               can_play;
	logic               tick_ge;
	logic               seg_end;
	logic [STEP_W-1:0]  eff_steps;
	logic               div_start;
	logic               div_done;
	logic signed [ANGLE_W:0]   diff;
	logic signed [ANGLE_W-1:0] quot;
	logic               last_joint;

	assign pose_in = {pointer_angle, thumb_angle, wrist_angle,
		little_angle, middle_angle, ring_angle};

	assign accept    = start && (state_q == ST_IDLE);
	assign room      = count_q < CW'(TABLE_DEPTH);
	assign can_play  = !playing_q && (count_q > CW'(1));
	assign eff_steps = (step_count_q == '0) ? STEP_W'(1) : step_count_q;
	assign tick_ge   = tick_q >= eff_steps;
	assign seg_end   = (SW'(seg_q) + SW'(3)) > SW'(count_q);
	assign wr_en     = accept && (command == CMD_STORE) && room;
	assign last_joint = joint_q == JOINT_W'(JOINTS - 1);

	assign diff = $signed({rd_data[{joint_q, 4'b0} + ANGLE_W - 1], rd_data[{joint_q, 4'b0} +: ANGLE_W]})
		- $signed({row_a_q[{joint_q, 4'b0} + ANGLE_W - 1], row_a_q[{joint_q, 4'b0} +: ANGLE_W]});

	// Saturating add of the increments, one lane per joint
	always_comb begin
		for (int j = 0; j < JOINTS; j++) begin
			pose_sum[j*ANGLE_W +: ANGLE_W] = sat17(
				$signed({cur_q[j*ANGLE_W + ANGLE_W - 1], cur_q[j*ANGLE_W +: ANGLE_W]})
				+ $signed({inc_q[j*ANGLE_W + ANGLE_W - 1], inc_q[j*ANGLE_W +: ANGLE_W]}));
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (command == CMD_PLAY && can_play)
						state_d = ST_RD_A;
					else if (command == CMD_TICK && playing_q && tick_ge && !seg_end)
						state_d = ST_RD_A;
				end
			end
			ST_RD_A:   state_d = ST_RD_B;
			ST_RD_B:   state_d = ST_DIV_GO;
			ST_DIV_GO: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_done)
					state_d = last_joint ? ST_IDLE : ST_DIV_GO;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = seg_q;
		div_start = 1'b0;
		busy      = 1'b1;
		case (state_q)
			ST_IDLE:   busy = 1'b0;
			ST_RD_A:   rd_en = 1'b1;
			ST_RD_B: begin
				rd_en   = 1'b1;
				rd_addr = seg_q + 1'b1;
			end
			ST_DIV_GO: div_start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_count_q <= STEP_COUNT_RESET;
			count_q      <= '0;
			playing_q    <= 1'b0;
			seg_q        <= '0;
			tick_q       <= '0;
			first_q      <= 1'b0;
			joint_q      <= '0;
			done_q       <= 1'b0;
			cur_q        <= '0;
			inc_q        <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= (accept || state_q != ST_IDLE) && state_d == ST_IDLE;
			if (cfg_wr_en) begin
				step_count_q <= cfg_wr_data;
			end
			if (accept) begin
				case (command)
					CMD_STORE: begin
						if (room) begin
							cur_q   <= pose_in;
							count_q <= count_q + 1'b1;
						end
					end
					CMD_PLAY: begin
						if (can_play) begin
							seg_q     <= '0;
							tick_q    <= '0;
							playing_q <= 1'b1;
							first_q   <= 1'b1;
						end else begin
							playing_q <= 1'b0;
						end
					end
					CMD_TICK: begin
						if (playing_q) begin
							if (tick_ge) begin
								if (seg_end) begin
									seg_q     <= '0;
									playing_q <= 1'b0;
								end else begin
									seg_q   <= seg_q + 1'b1;
									tick_q  <= '0;
									first_q <= 1'b0;
								end
							end else begin
								cur_q  <= pose_sum;
								tick_q <= tick_q + 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
			if (state_q == ST_RD_B) begin
				joint_q <= '0;
				// Play start jumps the pose to the first keyframe
				if (first_q)
					cur_q <= rd_data;
			end
			if (state_q == ST_DIV_WAIT && div_done) begin
				inc_q[{joint_q, 4'b0} +: ANGLE_W] <= quot;
				joint_q <= joint_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD_B)
			row_a_q <= rd_data;
	end

	kpi_pose_ram #(
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (pose_in),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	kpi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (diff),
		.divisor  (eff_steps),
		.done     (div_done),
		.quotient (quot)
	);

	assign done          = done_q;
	assign ring_now      = cur_q[0*ANGLE_W +: ANGLE_W];
	assign middle_now    = cur_q[1*ANGLE_W +: ANGLE_W];
	assign little_now    = cur_q[2*ANGLE_W +: ANGLE_W];
	assign wrist_now     = cur_q[3*ANGLE_W +: ANGLE_W];
	assign thumb_now     = cur_q[4*ANGLE_W +: ANGLE_W];
	assign pointer_now   = cur_q[5*ANGLE_W +: ANGLE_W];
	assign playing       = playing_q;
	assign frames_stored = 10'(count_q);

endmodule

// ===== test/tb_keyframe_pose_interpolator.sv =====
// ----------------------------------------------------------------------------
// tb_keyframe_pose_interpolator
// Self-checking bench for the keyframe pose player. Commands go in through
// the start/busy handshake while a local player model predicts every result
// transaction. Directed tests cover the empty table, extreme angles, step
// count limits and stores during playback. Random store/play/tick sequences
// follow, then the table is filled to capacity.
// ----------------------------------------------------------------------------
module tb_keyframe_pose_interpolator;

	import kpi_pkg::*;

	localparam int DEPTH      = 512;

	typedef logic signed [ANGLE_W-1:0] angle_t;

	typedef struct {
		cmd_t   op;
		angle_t ang [JOINTS];
	} pose_cmd_t;

	typedef struct {
		angle_t      pose [JOINTS];
		logic        playing;
		logic [9:0]  frames;
	} pose_result_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [STEP_W-1:0] cfg_wr_data;
	logic              start;
	logic              busy;
	logic [1:0]        command;
	angle_t            ring_angle, middle_angle, little_angle;
	angle_t            wrist_angle, thumb_angle, pointer_angle;
	logic              done;
	angle_t            ring_now, middle_now, little_now;
	angle_t            wrist_now, thumb_now, pointer_now;
	logic              playing;
	logic [9:0]        frames_stored;

	keyframe_pose_interpolator #(
		.TABLE_DEPTH(DEPTH)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.ring_angle   (ring_angle),
		.middle_angle (middle_angle),
		.little_angle (little_angle),
		.wrist_angle  (wrist_angle),
		.thumb_angle  (thumb_angle),
		.pointer_angle(pointer_angle),
		.done         (done),
		.ring_now     (ring_now),
		.middle_now   (middle_now),
		.little_now   (little_now),
		.wrist_now    (wrist_now),
		.thumb_now    (thumb_now),
		.pointer_now  (pointer_now),
		.playing      (playing),
		.frames_stored(frames_stored)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Player model state
	angle_t      kf_pose [DEPTH][JOINTS];
	int          kf_total   = 0;
	bit          kf_playing = 1'b0;
	int          seg_idx    = 0;
	int          tick_cnt   = 0;
	angle_t      seg_inc  [JOINTS] = '{default: '0};
	angle_t      cur_pose [JOINTS] = '{default: '0};
	logic [7:0]  steps_cfg = STEP_COUNT_RESET;

	pose_result_t expected_poses [$];
	int           fail_count = 0;
	bit           gaps_on    = 1'b0;
	int           burst_left = 0;

	string joint_name [JOINTS] = '{"ring_now", "middle_now", "little_now",
		"wrist_now", "thumb_now", "pointer_now"};

	function automatic angle_t clamp_angle(input int v);
		if (v > 32767)
			return angle_t'(32767);
		if (v < -32768)
			return angle_t'(-32768);
		return angle_t'(v);
	endfunction

	function automatic int eff_steps();
		return (steps_cfg == 0) ? 1 : int'(steps_cfg);
	endfunction

	function automatic void load_seg_increments();
		int diff;
		if (seg_idx + 1 >= DEPTH)
			return;
		for (int j = 0; j < JOINTS; j++) begin
			diff = int'(kf_pose[seg_idx + 1][j]) - int'(kf_pose[seg_idx][j]);
			// SV integer division truncates toward zero
			seg_inc[j] = clamp_angle(diff / eff_steps());
		end
	endfunction

	function automatic pose_result_t compute_next_pose(input pose_cmd_t it);
		pose_result_t r;
		case (it.op)
			CMD_STORE: begin
				if (kf_total < DEPTH) begin
					for (int j = 0; j < JOINTS; j++) begin
						kf_pose[kf_total][j] = it.ang[j];
						cur_pose[j] = it.ang[j];
					end
					kf_total++;
				end
			end
			CMD_PLAY: begin
				if (!kf_playing && kf_total > 1) begin
					for (int j = 0; j < JOINTS; j++)
						cur_pose[j] = kf_pose[0][j];
					seg_idx = 0;
					load_seg_increments();
					kf_playing = 1'b1;
					tick_cnt = 0;
				end else begin
					kf_playing = 1'b0;
				end
			end
			CMD_TICK: begin
				if (kf_playing) begin
					if (tick_cnt >= eff_steps()) begin
						seg_idx++;
						if (seg_idx + 2 > kf_total) begin
							seg_idx = 0;
							kf_playing = 1'b0;
						end else begin
							tick_cnt = 0;
							load_seg_increments();
						end
					end else begin
						for (int j = 0; j < JOINTS; j++)
							cur_pose[j] = clamp_angle(int'(cur_pose[j]) + int'(seg_inc[j]));
						tick_cnt = (tick_cnt + 1) & 8'hff;
					end
				end
			end
			default: begin
			end
		endcase
		r.pose    = cur_pose;
		r.playing = kf_playing;
		r.frames  = 10'(kf_total);
		return r;
	endfunction

	function automatic angle_t rand_angle();
		case ($urandom_range(0, 9))
			0: return angle_t'(-32768);
			1: return angle_t'(32767);
			2, 3, 4, 5: return angle_t'($urandom);
			default: return angle_t'(int'($urandom_range(0, 4095)) - 2048);
		endcase
	endfunction

	function automatic pose_cmd_t op_only(input cmd_t op);
		pose_cmd_t it;
		it.op = op;
		// angles are don't-care here; keep them moving anyway
		for (int j = 0; j < JOINTS; j++)
			it.ang[j] = angle_t'($urandom);
		return it;
	endfunction

	function automatic pose_cmd_t store_pose(input angle_t a0, a1, a2, a3, a4, a5);
		pose_cmd_t it;
		it.op  = CMD_STORE;
		it.ang = '{a0, a1, a2, a3, a4, a5};
		return it;
	endfunction

	function automatic pose_cmd_t store_random();
		pose_cmd_t it;
		it.op = CMD_STORE;
		for (int j = 0; j < JOINTS; j++)
			it.ang[j] = rand_angle();
		return it;
	endfunction

	task automatic send_cmd(input pose_cmd_t it);
		@(negedge clk);
		if (gaps_on && burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		start         <= 1'b1;
		command       <= it.op;
		ring_angle    <= it.ang[0];
		middle_angle  <= it.ang[1];
		little_angle  <= it.ang[2];
		wrist_angle   <= it.ang[3];
		thumb_angle   <= it.ang[4];
		pointer_angle <= it.ang[5];
		do
			@(posedge clk);
		while (busy);
		expected_poses.push_back(compute_next_pose(it));
		if (burst_left > 0)
			burst_left--;
	endtask

	task automatic do_op(input cmd_t op);
		send_cmd(op_only(op));
	endtask

	task automatic do_ticks(input int n);
		repeat (n) do_op(CMD_TICK);
	endtask

	// Hold off until every pending result transaction has come back
	task automatic wait_drain();
		@(negedge clk);
		start <= 1'b0;
		while (expected_poses.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_steps(input logic [7:0] v);
		wait_drain();
		repeat (2) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		steps_cfg = v;
	endtask

	task automatic note_mismatch(input string field, input int want, input int got);
		fail_count++;
		$error("%s: expected %0d, got %0d", field, want, got);
	endtask

	always @(posedge clk) begin : result_check
		pose_result_t want;
		angle_t       got [JOINTS];
		if (arst_n && done) begin
			got = '{ring_now, middle_now, little_now, wrist_now, thumb_now, pointer_now};
			if (expected_poses.size() == 0) begin
				fail_count++;
				$error("result transaction with no command pending");
			end else begin
				want = expected_poses.pop_front();
				for (int j = 0; j < JOINTS; j++)
					if (got[j] !== want.pose[j])
						note_mismatch(joint_name[j], want.pose[j], got[j]);
				if (playing !== want.playing)
					note_mismatch("playing", want.playing, playing);
				if (frames_stored !== want.frames)
					note_mismatch("frames_stored", want.frames, frames_stored);
			end
		end
	end

	// Ticks and plays on an empty table, plus the unused code
	task automatic test_empty_table();
		do_op(CMD_TICK);
		do_op(CMD_PLAY);
		do_op(CMD_IGNORE);
		wait_drain();
	endtask

	// Two extreme keyframes, single-frame play, stop while playing
	task automatic test_first_segment();
		gaps_on = 1'b1;
		send_cmd(store_pose(angle_t'(-32768), angle_t'(32767), angle_t'(0),
			angle_t'(-1), angle_t'(1), angle_t'(16'h5a5a)));
		do_op(CMD_PLAY);
		send_cmd(store_pose(angle_t'(32767), angle_t'(-32768), angle_t'(-1),
			angle_t'(0), angle_t'(256), angle_t'(16'ha5a5)));
		do_op(CMD_PLAY);
		do_ticks(3);
		do_op(CMD_IGNORE);
		do_op(CMD_PLAY);
		wait_drain();
	endtask

	// Saturating increments, step count zero, overflow after a mid-play store
	task automatic test_step_extremes();
		write_steps(8'd1);
		do_op(CMD_PLAY);
		do_ticks(3);
		write_steps(8'd0);
		do_op(CMD_PLAY);
		do_op(CMD_TICK);
		send_cmd(store_pose(angle_t'(32767), angle_t'(32767), angle_t'(32767),
			angle_t'(32767), angle_t'(-32768), angle_t'(32767)));
		do_ticks(2);
		write_steps(8'd255);
		do_op(CMD_PLAY);
		do_ticks(2);
		do_op(CMD_PLAY);
		wait_drain();
	endtask

	task automatic test_random_playback(input int n_items, input bit idle);
		int sent;
		int k;
		int n;
		gaps_on    = idle;
		burst_left = 0;
		sent       = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) < 7) begin
				// append a few frames, restart playback, then run it
				k = $urandom_range(1, 4);
				repeat (k) send_cmd(store_random());
				sent += k;
				if ($urandom_range(0, 19) == 0)
					wait_drain();
				if (kf_playing) begin
					do_op(CMD_PLAY);
					sent++;
				end
				do_op(CMD_PLAY);
				sent++;
				n = $urandom_range(1, (eff_steps() + 1) * 3);
				if (n > 300)
					n = 300;
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(0, 29) == 0)
						send_cmd(store_random());
					else
						do_op(CMD_TICK);
				end
				sent += n;
			end else begin
				if ($urandom_range(0, 3) == 0)
					send_cmd(store_random());
				else
					do_op(cmd_t'($urandom_range(1, 3)));
				sent++;
			end
		end
		wait_drain();
	endtask

	// Fill the table, then check that further stores are dropped
	task automatic test_full_table();
		gaps_on = 1'b1;
		while (kf_total < DEPTH)
			send_cmd(store_random());
		send_cmd(store_random());
		if (kf_playing)
			do_op(CMD_PLAY);
		do_op(CMD_PLAY);
		do_ticks(4);
		send_cmd(store_random());
		do_op(CMD_TICK);
		do_op(CMD_PLAY);
		send_cmd(store_random());
		wait_drain();
	endtask

	initial begin : main_seq
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		start         = 1'b0;
		command       = CMD_STORE;
		ring_angle    = '0;
		middle_angle  = '0;
		little_angle  = '0;
		wrist_angle   = '0;
		thumb_angle   = '0;
		pointer_angle = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_first_segment();
		test_step_extremes();

		write_steps(8'd1);
		test_random_playback(220, 1'b1);
		write_steps(8'd0);
		test_random_playback(220, 1'b0);
		write_steps(8'($urandom_range(2, 12)));
		test_random_playback(220, 1'b1);
		write_steps(8'd255);
		test_random_playback(220, 1'b1);
		write_steps(8'($urandom_range(1, 255)));
		test_random_playback(220, 1'b0);
		write_steps(8'd3);
		test_random_playback(220, 1'b1);

		write_steps(8'd1);
		test_full_table();

		wait_drain();
		repeat (60) @(posedge clk);
		if (fail_count == 0 && expected_poses.size() == 0)
			$display("[keyframe_pose_interpolator] OK");
		else
			$display("[keyframe_pose_interpolator] ERROR");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("[keyframe_pose_interpolator] ERROR");
		$finish;
	end

endmodule
